FILE: rtl/core/rhsv_pkg.sv
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared widths and pipeline sizing for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhsv_pkg;

  // Width of one color channel, of value and of every divisor.
  localparam int CH_W       = 8;
  // Hue output: 9 integer bits and 6 fractional bits.
  localparam int HUE_W      = 15;
  // Saturation quotient width.
  localparam int SAT_W      = 8;
  // Width of the sector-offset term t, which stays below 6 * 255.
  localparam int T_W        = 11;
  // Hue numerator 3840 * t stays below 2**23.
  localparam int HNUM_W     = T_W + 12;
  // Saturation numerator 255 * d.
  localparam int SNUM_W     = CH_W + SAT_W;
  // Quotient bits resolved in one pipeline stage.
  localparam int DIV_STEPS  = 4;
  // Division stages, set by the wider (hue) quotient.
  localparam int DIV_STAGES = (HUE_W + DIV_STEPS - 1) / DIV_STEPS;
  // All register stages: min/max, numerator setup, then the division stages.
  localparam int NSTG       = DIV_STAGES + 2;
  // First hue code that is out of range (360 degrees times 64).
  localparam logic [HUE_W-1:0] HUE_LIMIT = HUE_W'(23040);

endpackage

FILE: rtl/core/rhsv_div_step.sv
// ----------------------------------------------------------------------------
// rhsv_div_step
// A few unrolled steps of restoring long division by an 8-bit divisor.
// ----------------------------------------------------------------------------
module rhsv_div_step #(
  parameter int QW    = 15,
  parameter int STEPS = 4
) (
  input  logic [rhsv_pkg::CH_W-1:0] div_i,
  input  logic [rhsv_pkg::CH_W-1:0] rem_i,
  input  logic [QW-1:0]             quo_i,
  output logic [rhsv_pkg::CH_W-1:0] rem_o,
  output logic [QW-1:0]             quo_o
);

  // The quotient register starts out holding the low numerator bits; each
  // step shifts one numerator bit into the remainder and one quotient bit in.
  always_comb begin
    logic [rhsv_pkg::CH_W-1:0] r;
    logic [QW-1:0]             q;
    logic [rhsv_pkg::CH_W:0]   rr;
    logic                      qbit;
    r = rem_i;
    q = quo_i;
    for (int i = 0; i < STEPS; i++) begin
      rr = {r, q[QW-1]};
      if (rr >= {1'b0, div_i}) begin
        rr   = rr - {1'b0, div_i};
        qbit = 1'b1;
      end else begin
        qbit = 1'b0;
      end
      r = rr[rhsv_pkg::CH_W-1:0];
      q = {q[QW-2:0], qbit};
    end
    rem_o = r;
    quo_o = q;
  end

endmodule

FILE: rtl/core/rgb_to_hsv_converter_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit
// Streaming RGB to HSV conversion, one pixel per clock when not stalled.
// ----------------------------------------------------------------------------
// The unit takes one 8-bit RGB word per clock while the output is not
// stalled, so a continuous pixel stream passes at full clock rate. Value is
// the largest channel, saturation is floor(255*(max-min)/max) and hue is
// floor(64*degrees) with six fractional bits, in the range 0 to 23039; grey
// and black pixels give zero hue and zero saturation. The hue division sets
// the pipeline depth: its 15 quotient bits are resolved up to four per stage
// over four stages, behind one stage that finds max and min and one that
// forms the numerators. Each stage has its own valid bit and loads whenever
// it is empty or its word moves on, so bubbles close up and a word waiting
// at the output does not keep new words out until the pipeline is full.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rhsv_pkg::CH_W-1:0]    red_in_i,
  input  logic [rhsv_pkg::CH_W-1:0]    green_in_i,
  input  logic [rhsv_pkg::CH_W-1:0]    blue_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rhsv_pkg::HUE_W-1:0]   hue_out_o,
  output logic [rhsv_pkg::SAT_W-1:0]   sat_out_o,
  output logic [rhsv_pkg::CH_W-1:0]    val_out_o
);

  localparam int CW = rhsv_pkg::CH_W;
  localparam int HW = rhsv_pkg::HUE_W;
  localparam int SW = rhsv_pkg::SAT_W;
  localparam int TW = rhsv_pkg::T_W;
  localparam int NS = rhsv_pkg::DIV_STAGES;
  localparam int NG = rhsv_pkg::NSTG;
  localparam int ST = rhsv_pkg::DIV_STEPS;

  // Per-stage valid bits and load enables. Stage 0 holds max/difference/t,
  // stage 1 the numerators and stage k+2 the result of division stage k.
  logic [NG-1:0] vld_q;
  logic [NG-1:0] ld;

  // Stage 0: max, difference and the sector-offset term t.
  logic [CW-1:0] a_mx_d, a_mx_q;
  logic [CW-1:0] a_dif_d, a_dif_q;
  logic [TW-1:0] a_t_d, a_t_q;

  // Division stages.
  logic [CW-1:0] hrem_d [NS+1];
  logic [CW-1:0] hrem_q [NS+1];
  logic [HW-1:0] hquo_d [NS+1];
  logic [HW-1:0] hquo_q [NS+1];
  logic [CW-1:0] srem_d [NS+1];
  logic [CW-1:0] srem_q [NS+1];
  logic [SW-1:0] squo_d [NS+1];
  logic [SW-1:0] squo_q [NS+1];
  logic [CW-1:0] hdiv_d [NS+1];
  logic [CW-1:0] hdiv_q [NS+1];
  logic [CW-1:0] sdiv_d [NS+1];
  logic [CW-1:0] sdiv_q [NS+1];
  logic [CW-1:0] mx_d   [NS+1];
  logic [CW-1:0] mx_q   [NS+1];

  // Flow control: a stage loads when it is empty or its word leaves.
  always_comb begin
    ld[NG-1] = !vld_q[NG-1] || !out_stall_i;
    for (int k = NG - 2; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  assign in_stall_o = !ld[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NG; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 0. The sector is picked with red first, then green, then blue
  // among equal maxima. For a grey pixel red wins with g >= b, so t is zero.
  always_comb begin
    logic [CW-1:0] mn;
    logic [TW-1:0] r_w, g_w, b_w, d_w, d6;
    a_mx_d = red_in_i;
    mn     = red_in_i;
    if (green_in_i > a_mx_d) a_mx_d = green_in_i;
    if (blue_in_i  > a_mx_d) a_mx_d = blue_in_i;
    if (green_in_i < mn)     mn     = green_in_i;
    if (blue_in_i  < mn)     mn     = blue_in_i;
    a_dif_d = a_mx_d - mn;
    r_w = TW'(red_in_i);
    g_w = TW'(green_in_i);
    b_w = TW'(blue_in_i);
    d_w = TW'(a_dif_d);
    d6  = (d_w << 2) + (d_w << 1);
    if (red_in_i == a_mx_d) begin
      if (green_in_i >= blue_in_i) begin
        a_t_d = g_w - b_w;
      end else begin
        a_t_d = d6 - (b_w - g_w);
      end
    end else if (green_in_i == a_mx_d) begin
      a_t_d = (d_w << 1) + b_w - r_w;
    end else begin
      a_t_d = (d_w << 2) + r_w - g_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      a_mx_q  <= a_mx_d;
      a_dif_q <= a_dif_d;
      a_t_q   <= a_t_d;
    end
  end

  // Numerator setup. 3840*t and 255*d are shift-and-subtract. The high
  // numerator bits seed the remainder; they are always below the divisor
  // because the quotients fit their widths. A zero divisor only occurs with
  // a zero numerator and is replaced by one so that the quotient is zero.
  always_comb begin
    logic [rhsv_pkg::HNUM_W-1:0] hnum;
    logic [rhsv_pkg::SNUM_W-1:0] snum;
    hnum = {a_t_q, 12'b0} - {4'b0, a_t_q, 8'b0};
    snum = {a_dif_q, 8'b0} - {8'b0, a_dif_q};
    hrem_d[0] = hnum[rhsv_pkg::HNUM_W-1:HW];
    hquo_d[0] = hnum[HW-1:0];
    srem_d[0] = snum[rhsv_pkg::SNUM_W-1:SW];
    squo_d[0] = snum[SW-1:0];
    hdiv_d[0] = (a_dif_q == '0) ? CW'(1) : a_dif_q;
    sdiv_d[0] = (a_mx_q == '0) ? CW'(1) : a_mx_q;
    mx_d[0]   = a_mx_q;
  end

  // Division stages: each resolves up to four quotient bits of each lane.
  for (genvar s = 0; s < NS; s++) begin : g_div
    localparam int HSTEPS = (HW - ST * s > ST) ? ST : HW - ST * s;
    localparam int SSTEPS = (SW - ST * s > ST) ? ST : SW - ST * s;

    rhsv_div_step #(
      .QW    (HW),
      .STEPS (HSTEPS)
    ) u_hue_step (
      .div_i (hdiv_q[s]),
      .rem_i (hrem_q[s]),
      .quo_i (hquo_q[s]),
      .rem_o (hrem_d[s+1]),
      .quo_o (hquo_d[s+1])
    );

    if (SSTEPS > 0) begin : g_sat
      rhsv_div_step #(
        .QW    (SW),
        .STEPS (SSTEPS)
      ) u_sat_step (
        .div_i (sdiv_q[s]),
        .rem_i (srem_q[s]),
        .quo_i (squo_q[s]),
        .rem_o (srem_d[s+1]),
        .quo_o (squo_d[s+1])
      );
    end else begin : g_sat_hold
      assign srem_d[s+1] = srem_q[s];
      assign squo_d[s+1] = squo_q[s];
    end

    assign hdiv_d[s+1] = hdiv_q[s];
    assign sdiv_d[s+1] = sdiv_q[s];
    assign mx_d[s+1]   = mx_q[s];
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s <= NS; s++) begin
      if (ld[s+1]) begin
        hrem_q[s] <= hrem_d[s];
        hquo_q[s] <= hquo_d[s];
        srem_q[s] <= srem_d[s];
        squo_q[s] <= squo_d[s];
        hdiv_q[s] <= hdiv_d[s];
        sdiv_q[s] <= sdiv_d[s];
        mx_q[s]   <= mx_d[s];
      end
    end
  end

  // The last division stage is the output register.
  assign out_valid_o = vld_q[NG-1];
  assign hue_out_o   = hquo_q[NS];
  assign sat_out_o   = squo_q[NS];
  assign val_out_o   = mx_q[NS];

`ifndef ASSERT_OFF
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hue_out_o < rhsv_pkg::HUE_LIMIT))
    else $error("hue word out of range");

  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (sat_out_o == '0)) |-> (hue_out_o == '0))
    else $error("nonzero hue with zero saturation");

  a_black_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (val_out_o == '0)) |-> (sat_out_o == '0))
    else $error("nonzero saturation for a black pixel");

  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted word did not enter the first stage");
`endif

endmodule

FILE: test/tb_rgb_to_hsv_converter_unit.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_converter_unit
// Self-checking stream test of the RGB to HSV converter: a directed set of
// corner pixels, then random pixel streams under changing flow control.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH_W  = rhsv_pkg::CH_W;
  localparam int HUE_W = rhsv_pkg::HUE_W;
  localparam int SAT_W = rhsv_pkg::SAT_W;
  localparam int NSTG  = rhsv_pkg::NSTG;

  // Cycles with no word moving in or out before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the forced output hold in the back-pressure test.
  localparam int LONG_HOLD      = 150;
  // Only this many failures are described in detail.
  localparam int REPORT_LIMIT   = 10;
  // Cycles allowed after the last result for stray output words to show up.
  localparam int DRAIN_CYCLES   = 3 * NSTG;
  // 360 degrees times 64 fractional steps, divided by the six hue sectors.
  localparam int unsigned SECTOR_SCALE = 3840;
  localparam int unsigned SAT_SCALE    = 255;

  // One expected output word, with the pixel that caused it kept for reports.
  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [CH_W-1:0]  val;
  } hsv_word_t;

  // Shapes of random pixels; the biased ones steer the stream toward tied
  // maxima, grey pixels and values close to black.
  typedef enum int unsigned {
    PIX_ANY,
    PIX_TIE_RG,
    PIX_TIE_GB,
    PIX_TIE_RB,
    PIX_GREY,
    PIX_NEAR_BLACK
  } pixel_shape_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [CH_W-1:0]   red_in_i    = '0;
  logic [CH_W-1:0]   green_in_i  = '0;
  logic [CH_W-1:0]   blue_in_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [HUE_W-1:0]  hue_out_o;
  logic [SAT_W-1:0]  sat_out_o;
  logic [CH_W-1:0]   val_out_o;

  // Expected HSV words, oldest first.
  hsv_word_t pending_hsv_q[$];

  // Flow-control knobs of the current phase, in percent per cycle.
  int unsigned sender_idle_pct  = 0;
  int unsigned recv_stall_pct   = 0;

  // The hold request is a toggle so that the stall process alone owns its
  // counter; the test flips hold_req and the process answers with hold_ack.
  bit          hold_req   = 1'b0;
  bit          hold_ack   = 1'b0;
  int unsigned hold_left  = 0;

  int unsigned fail_count        = 0;
  int unsigned pixels_in         = 0;
  int unsigned words_out         = 0;
  int unsigned grey_pixels       = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned idle_cycles       = 0;

  rgb_to_hsv_converter_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hue_out_o   (hue_out_o),
    .sat_out_o   (sat_out_o),
    .val_out_o   (val_out_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Expected HSV word of one pixel. Hue is worked out per sector as a
  // non-negative offset t in units of the spread, then scaled by 3840/spread,
  // which gives degrees times 64 rounded down.
  function automatic hsv_word_t convert_pixel(input logic [CH_W-1:0] r,
                                              input logic [CH_W-1:0] g,
                                              input logic [CH_W-1:0] b);
    int unsigned ri, gi, bi, hi, lo, spread, offset;
    hsv_word_t   w;
    ri = r;
    gi = g;
    bi = b;
    hi = ri;
    lo = ri;
    if (gi > hi) hi = gi;
    if (bi > hi) hi = bi;
    if (gi < lo) lo = gi;
    if (bi < lo) lo = bi;
    spread = hi - lo;
    w.red   = r;
    w.green = g;
    w.blue  = b;
    w.val   = CH_W'(hi);
    w.sat   = '0;
    w.hue   = '0;
    if (hi != 0) w.sat = SAT_W'((SAT_SCALE * spread) / hi);
    if (w.sat != 0 && spread != 0) begin
      // Red wins ties over green and blue, green wins over blue.
      if (ri == hi) begin
        // A red maximum with blue above green wraps below zero degrees.
        offset = (gi >= bi) ? gi - bi : 6 * spread - (bi - gi);
      end else if (gi == hi) begin
        offset = 2 * spread + bi - ri;
      end else begin
        offset = 4 * spread + ri - gi;
      end
      w.hue = HUE_W'((SECTOR_SCALE * offset) / spread);
    end
    return w;
  endfunction

  // Receiver side: random stalls at the phase rate, or a forced long hold.
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor and checker. Both handshakes are sampled at the rising edge, so
  // each sees the values that were present when the word moved. The input
  // side is handled first so that a word could never be checked ahead of its
  // own prediction.
  always @(posedge clk_i) begin
    hsv_word_t want;
    logic      moved;
    moved = 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pending_hsv_q.push_back(convert_pixel(red_in_i, green_in_i, blue_in_i));
      pixels_in++;
      moved = 1'b1;
      if (red_in_i == green_in_i && green_in_i == blue_in_i) grey_pixels++;
    end
    if (rst_ni && in_valid_i && in_stall_o) input_stall_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_out++;
      moved = 1'b1;
      if (pending_hsv_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%t: unexpected HSV word hue=%0d sat=%0d val=%0d", $realtime,
                   hue_out_o, sat_out_o, val_out_o);
      end else begin
        want = pending_hsv_q.pop_front();
        if (hue_out_o !== want.hue || sat_out_o !== want.sat ||
            val_out_o !== want.val) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%t: rgb=(%0d,%0d,%0d) expected h/s/v=%0d/%0d/%0d got %0d/%0d/%0d",
                     $realtime, want.red, want.green, want.blue, want.hue,
                     want.sat, want.val, hue_out_o, sat_out_o, val_out_o);
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one pixel and returns at the edge where it is taken. Random idle
  // cycles go in front of the word; valid stays high between back-to-back
  // words so it is never lowered and raised in the same step.
  task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Sender goes quiet until every expected word has come back. At least one
  // edge passes first, so the last accepted pixel is already queued.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_hsv_q.size() != 0);
  endtask

  task automatic send_random_pixel();
    logic [CH_W-1:0] r, g, b;
    pixel_shape_e    shape;
    r = CH_W'($urandom);
    g = CH_W'($urandom);
    b = CH_W'($urandom);
    if ($urandom_range(1)) shape = PIX_ANY;
    else shape = pixel_shape_e'($urandom_range(PIX_NEAR_BLACK));
    case (shape)
      PIX_TIE_RG: begin
        g = r;
      end
      PIX_TIE_GB: begin
        b = g;
      end
      PIX_TIE_RB: begin
        b = r;
      end
      PIX_GREY: begin
        g = r;
        b = r;
      end
      PIX_NEAR_BLACK: begin
        r = CH_W'($urandom_range(3));
        g = CH_W'($urandom_range(3));
        b = CH_W'($urandom_range(3));
      end
      default: begin
      end
    endcase
    send_pixel(r, g, b);
  endtask

  // One random phase with the given idle and stall rates, drained at the end.
  task automatic run_random_pixels(input int unsigned count,
                                   input int unsigned idle_pct,
                                   input int unsigned stall_pct);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    repeat (count) send_random_pixel();
    wait_until_drained();
  endtask

  task automatic apply_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  // Black, white and grey pixels, pure primaries, every tie between maxima,
  // the red sector on both sides of zero degrees, and smallest spreads.
  task automatic test_directed_pixels();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd77,  8'd77,  8'd77);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd1,   8'd0);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd253);
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd50,  8'd200, 8'd100);
    send_pixel(8'd100, 8'd50,  8'd200);
    send_pixel(8'hAA,  8'h55,  8'h00);
    send_pixel(8'h55,  8'hAA,  8'hFF);
    send_pixel(8'd128, 8'd127, 8'd129);
    wait_until_drained();
  endtask

  task automatic test_free_flow();
    run_random_pixels(400, 0, 0);
  endtask

  task automatic test_sparse_sender();
    run_random_pixels(300, 71, 0);
  endtask

  task automatic test_stalling_receiver();
    run_random_pixels(300, 0, 71);
  endtask

  task automatic test_mixed_idling();
    run_random_pixels(450, 10, 10);
  endtask

  // The receiver holds off for a long stretch while the sender keeps going,
  // so the pipeline fills and must push back on its input.
  task automatic test_output_hold();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_req <= ~hold_req;
    repeat (60) send_random_pixel();
    wait_until_drained();
  endtask

  initial begin
    apply_reset();
    test_directed_pixels();
    test_free_flow();
    test_sparse_sender();
    test_stalling_receiver();
    test_mixed_idling();
    test_output_hold();
    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_hsv_q.size() != 0) begin
      fail_count++;
      $display("%0d expected HSV words never arrived", pending_hsv_q.size());
    end
    $display("Converted %0d pixels (%0d grey or black) into %0d HSV words.",
             pixels_in, grey_pixels, words_out);
    $display("Flow: free running, sparse sender, stalling receiver, mixed, and a %0d-cycle %s",
             LONG_HOLD, $sformatf("output hold (%0d input stall cycles)",
                                  input_stall_cycles));
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d failures", fail_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
